>>> rtl/vbec_pkg.sv
// Shared widths, payload structs and register indexes for the velocity clipper.
`default_nettype none
package vbec_pkg;
   localparam int VEL_W = 16;                 // velocity word width
   localparam int LIM_W = 15;                 // limit / semi-axis width
   localparam int OFF_W = 16;                 // offset width
   localparam int CSR_W = 16;                 // widest register
   localparam int IDX_W = 3;
   localparam int S_W   = 2 * VEL_W + 2;      // sum of three squares
   localparam int P_W   = LIM_W + VEL_W;      // semi-axis times magnitude
   localparam int R_W   = 2 * P_W;            // square of that, root remainder
   localparam int T_W   = LIM_W + 1;          // trial term 2*lim + 2^b
   localparam int D_W   = T_W + S_W + LIM_W;  // shifted trial product
   localparam int C_W   = ((VEL_W > OFF_W) ? VEL_W : OFF_W) + 2;
   localparam int B_W   = 4;                  // root bit index
   localparam int NROOT = LIM_W;              // one root stage per result bit
   localparam int NSTG  = 4 + NROOT + 1;      // front, root, clamp

   typedef enum logic [IDX_W-1:0] {
      REG_MODE  = 3'd0,
      REG_LIM_X = 3'd1,
      REG_LIM_Y = 3'd2,
      REG_LIM_Z = 3'd3,
      REG_OFF_X = 3'd4,
      REG_OFF_Y = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] x;
      logic signed [VEL_W-1:0] y;
      logic signed [VEL_W-1:0] z;
   } vel_type;

   typedef struct packed {
      vel_type                    vel;
      logic [S_W-1:0]             s;
      logic [2:0][LIM_W-1:0]      lim;
      logic [2:0][R_W-1:0]        r;
   } root_type;

   typedef struct packed {
      logic [LIM_W-1:0] lim_x;
      logic [LIM_W-1:0] lim_y;
      logic [LIM_W-1:0] lim_z;
   } lims_type;
endpackage
`default_nettype wire

>>> rtl/vbec_front.sv
// Front stages: magnitudes, squares, norm sum, scaled magnitudes and their squares.
`default_nettype none
module vbec_front (
   input  wire logic                   clock,
   input  wire logic [3:0]             en,
   input  wire vbec_pkg::vel_type      req_vel,
   input  wire vbec_pkg::lims_type     lims,
   output vbec_pkg::root_type          out_ff
);
   import vbec_pkg::*;

   vel_type                 v0_ff, v1_ff, v2_ff;
   logic [2:0][VEL_W-1:0]   mag1_ff;
   logic [2:0][2*VEL_W-1:0] sq1_ff;
   logic [S_W-1:0]          s2_ff;
   logic [2:0][P_W-1:0]     p2_ff;
   logic [2:0][VEL_W-1:0]   mag_in;
   logic [2:0][LIM_W-1:0]   lim_sel;
   root_type                out_in;

   always_comb begin
      mag_in[0] = v0_ff.x[VEL_W-1] ? VEL_W'(-v0_ff.x) : VEL_W'(v0_ff.x);
      mag_in[1] = v0_ff.y[VEL_W-1] ? VEL_W'(-v0_ff.y) : VEL_W'(v0_ff.y);
      mag_in[2] = v0_ff.z[VEL_W-1] ? VEL_W'(-v0_ff.z) : VEL_W'(v0_ff.z);
      lim_sel[0] = lims.lim_x;
      lim_sel[1] = lims.lim_y;
      lim_sel[2] = lims.lim_z;
      out_in.vel = v2_ff;
      out_in.s   = s2_ff;
      out_in.lim = '0;
      for (int a = 0; a < 3; a++) begin
         out_in.r[a] = R_W'(p2_ff[a]) * R_W'(p2_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         v0_ff <= req_vel;
      end
      if (en[1]) begin
         v1_ff   <= v0_ff;
         mag1_ff <= mag_in;
         for (int a = 0; a < 3; a++) begin
            sq1_ff[a] <= (2*VEL_W)'(mag_in[a]) * (2*VEL_W)'(mag_in[a]);
         end
      end
      if (en[2]) begin
         v2_ff   <= v1_ff;
         s2_ff   <= S_W'(sq1_ff[0]) + S_W'(sq1_ff[1]) + S_W'(sq1_ff[2]);
         for (int a = 0; a < 3; a++) begin
            p2_ff[a] <= P_W'(lim_sel[a]) * P_W'(mag1_ff[a]);
         end
      end
      if (en[3]) begin
         out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/vbec_root.sv
// One restoring step of floor(P / sqrt(s)) for all three axes.
`default_nettype none
module vbec_root (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [vbec_pkg::B_W-1:0] bit_idx,
   input  wire vbec_pkg::root_type     in_data,
   output vbec_pkg::root_type          out_ff
);
   import vbec_pkg::*;

   root_type        out_in;
   logic [T_W-1:0]  one_b;
   logic [T_W-1:0]  trial;
   logic [D_W-1:0]  d;

   always_comb begin
      out_in = in_data;
      one_b  = T_W'(1) << bit_idx;
      trial  = '0;
      d      = '0;
      for (int a = 0; a < 3; a++) begin
         // remainder holds P^2 - lim^2*s; try setting this bit
         trial = {in_data.lim[a], 1'b0} | one_b;
         d     = (D_W'(trial) * D_W'(in_data.s)) << bit_idx;
         if (d <= D_W'(in_data.r[a])) begin
            out_in.r[a]   = in_data.r[a] - R_W'(d);
            out_in.lim[a] = in_data.lim[a] | one_b[LIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/vbec_clamp.sv
// Output stage: chooses the limits and clamps each axis to its offset bounds.
`default_nettype none
module vbec_clamp (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire vbec_pkg::root_type            in_data,
   input  wire logic                          mode,
   input  wire vbec_pkg::lims_type            lims,
   input  wire logic signed [vbec_pkg::OFF_W-1:0] off_x,
   input  wire logic signed [vbec_pkg::OFF_W-1:0] off_y,
   output vbec_pkg::vel_type                  out_ff
);
   import vbec_pkg::*;

   vel_type out_in;

   function automatic logic signed [VEL_W-1:0] clamp_off(
      input logic signed [VEL_W-1:0] v,
      input logic [LIM_W-1:0]        lim,
      input logic signed [OFF_W-1:0] off
   );
      logic signed [C_W-1:0] lo;
      logic signed [C_W-1:0] hi;
      logic signed [C_W-1:0] vv;
      logic signed [C_W-1:0] r;
      lo = C_W'(off) - $signed(C_W'(lim));
      hi = C_W'(off) + $signed(C_W'(lim));
      vv = C_W'(v);
      if (lo > 0) lo = '0;
      if (hi < 0) hi = '0;
      r = vv;
      if (vv < lo) r = lo;
      if (vv > hi) r = hi;
      return r[VEL_W-1:0];
   endfunction

   always_comb begin
      if (mode) begin
         out_in.x = clamp_off(in_data.vel.x, in_data.lim[0], off_x);
         out_in.y = clamp_off(in_data.vel.y, in_data.lim[1], off_y);
         out_in.z = clamp_off(in_data.vel.z, in_data.lim[2], '0);
      end else begin
         out_in.x = clamp_off(in_data.vel.x, lims.lim_x, off_x);
         out_in.y = clamp_off(in_data.vel.y, lims.lim_y, off_y);
         out_in.z = clamp_off(in_data.vel.z, lims.lim_z, '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/velocity_box_ellipsoid_clipper.sv
// Top level of the velocity box / ellipsoid clipper.
`default_nettype none
// Clips a 3-axis velocity request (signed Q6.10). Box mode clamps x and y to
// [min(-L+o,0), max(L+o,0)] and z to +/-Lz. Ellipsoid mode replaces each L by
// floor(L*|v|/n), n the exact 3-D norm, worked out by a restoring root/divide
// with one result bit per stage. Fully pipelined: one request per cycle unless
// the full pipe is stalled (stages: 4 front, 15 root, one clamp/output).
// Every stage holds while the one after it is full and stalled, so a stalled
// response never blocks requests until the whole pipe is full. Registers are
// read live by the stages; write them only while the pipe is empty.
module velocity_box_ellipsoid_clipper (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [vbec_pkg::VEL_W-1:0] req_desired_x,
   input  wire logic signed [vbec_pkg::VEL_W-1:0] req_desired_y,
   input  wire logic signed [vbec_pkg::VEL_W-1:0] req_desired_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [vbec_pkg::VEL_W-1:0]  rsp_clipped_x,
   output logic signed [vbec_pkg::VEL_W-1:0]  rsp_clipped_y,
   output logic signed [vbec_pkg::VEL_W-1:0]  rsp_clipped_z,
   input  wire logic                          csr_we,
   input  wire logic [vbec_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [vbec_pkg::CSR_W-1:0]    csr_wdata
);
   import vbec_pkg::*;

   // configuration registers
   logic                    mode_ff;
   lims_type                lims_ff;
   logic signed [OFF_W-1:0] offx_ff, offy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         lims_ff <= '{lim_x: '1, lim_y: '1, lim_z: '1};
         offx_ff <= '0;
         offy_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:  mode_ff       <= csr_wdata[0];
            REG_LIM_X: lims_ff.lim_x <= csr_wdata[LIM_W-1:0];
            REG_LIM_Y: lims_ff.lim_y <= csr_wdata[LIM_W-1:0];
            REG_LIM_Z: lims_ff.lim_z <= csr_wdata[LIM_W-1:0];
            REG_OFF_X: offx_ff       <= csr_wdata[OFF_W-1:0];
            REG_OFF_Y: offy_ff       <= csr_wdata[OFF_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits and enable chain: a stage loads when empty or when it moves on
   logic [NSTG-1:0] vld_ff;
   logic [NSTG:0]   en;

   always_comb begin
      en[NSTG] = !rsp_stall;
      for (int k = NSTG - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NSTG-1];

   vel_type  req_vel;
   root_type root_d [NROOT+1];
   vel_type  rsp_ff;

   assign req_vel = '{x: req_desired_x, y: req_desired_y, z: req_desired_z};

   vbec_front u_front (
      .clock   (clock),
      .en      (en[3:0]),
      .req_vel (req_vel),
      .lims    (lims_ff),
      .out_ff  (root_d[0])
   );

   // most significant limit bit first
   for (genvar i = 0; i < NROOT; i++) begin : g_root
      vbec_root u_root (
         .clock   (clock),
         .en      (en[4+i]),
         .bit_idx (B_W'(NROOT - 1 - i)),
         .in_data (root_d[i]),
         .out_ff  (root_d[i+1])
      );
   end

   vbec_clamp u_clamp (
      .clock   (clock),
      .en      (en[NSTG-1]),
      .in_data (root_d[NROOT]),
      .mode    (mode_ff),
      .lims    (lims_ff),
      .off_x   (offx_ff),
      .off_y   (offy_ff),
      .out_ff  (rsp_ff)
   );

   assign rsp_clipped_x = rsp_ff.x;
   assign rsp_clipped_y = rsp_ff.y;
   assign rsp_clipped_z = rsp_ff.z;
endmodule
`default_nettype wire

>>> sim/velocity_box_ellipsoid_clipper_tb.sv
// Self-checking testbench for the velocity box / ellipsoid clipper.
`default_nettype none
module velocity_box_ellipsoid_clipper_tb;
   import vbec_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [VEL_W-1:0] req_desired_x, req_desired_y, req_desired_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [VEL_W-1:0] rsp_clipped_x, rsp_clipped_y, rsp_clipped_z;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   // Local copy of the register file, updated on every write we issue
   logic            mode_q;
   logic [LIM_W-1:0] lim_x_q, lim_y_q, lim_z_q;
   logic signed [OFF_W-1:0] off_x_q, off_y_q;

   vel_type clipped_expected[$];
   int      mismatches;
   bit      quiet_tx;   // turns off random request gaps
   bit      quiet_rx;   // turns off random response stalls

   velocity_box_ellipsoid_clipper dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous ceiling: ~2000 requests with 20% gaps and 20% stalls
   initial begin
      #4000000;
      $display("velocity_box_ellipsoid_clipper verification failed");
      $finish;
   end

   // floor(semi*t/sqrt(s)): largest L with L*L*s <= (semi*t)^2
   function automatic longint unsigned ellipse_limit(longint unsigned semi,
         longint unsigned t, longint unsigned s);
      logic [127:0] rhs;
      logic [127:0] lhs;
      longint unsigned lim;
      longint unsigned cand;
      rhs = 128'(semi * t) * 128'(semi * t);
      lim = 0;
      for (int b = 14; b >= 0; b--) begin
         cand = lim | (64'd1 << b);
         lhs  = 128'(cand * cand) * 128'(s);
         if (lhs <= rhs) lim = cand;
      end
      return lim;
   endfunction

   function automatic longint bound_clamp(longint v, longint unsigned lim, longint off);
      longint lo;
      longint hi;
      lo = -longint'(lim) + off;
      hi = longint'(lim) + off;
      if (lo > 0) lo = 0;
      if (hi < 0) hi = 0;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic vel_type clip_velocity(vel_type d);
      vel_type r;
      longint x, y, z;
      longint unsigned ax, ay, az, s;
      x = d.x; y = d.y; z = d.z;
      r = d;
      if (!mode_q) begin
         r.x = VEL_W'(bound_clamp(x, lim_x_q, off_x_q));
         r.y = VEL_W'(bound_clamp(y, lim_y_q, off_y_q));
         r.z = VEL_W'(bound_clamp(z, lim_z_q, 0));
      end else if (x == 0 && y == 0) begin
         // on the z axis: x, y pass through
         r.z = VEL_W'(bound_clamp(z, lim_z_q, 0));
      end else begin
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         az = (z < 0) ? -z : z;
         s  = ax*ax + ay*ay + az*az;
         r.x = VEL_W'(bound_clamp(x, ellipse_limit(lim_x_q, ax, s), off_x_q));
         r.y = VEL_W'(bound_clamp(y, ellipse_limit(lim_y_q, ay, s), off_y_q));
         r.z = VEL_W'(bound_clamp(z, ellipse_limit(lim_z_q, az, s), 0));
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Response checker and random stall generator
   initial begin
      vel_type want;
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (clipped_expected.size() == 0) begin
               report_mismatch("unexpected response", rsp_clipped_x, 0);
            end else begin
               want = clipped_expected.pop_front();
               if (rsp_clipped_x !== want.x) report_mismatch("x", rsp_clipped_x, want.x);
               if (rsp_clipped_y !== want.y) report_mismatch("y", rsp_clipped_y, want.y);
               if (rsp_clipped_z !== want.z) report_mismatch("z", rsp_clipped_z, want.z);
            end
         end
         rsp_stall <= reset ? 1'b0 : (!quiet_rx && ($urandom_range(99) < 20));
      end
   end

   task automatic write_reg(reg_idx_type idx, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      case (idx)
         REG_MODE:  mode_q  = value[0];
         REG_LIM_X: lim_x_q = value[LIM_W-1:0];
         REG_LIM_Y: lim_y_q = value[LIM_W-1:0];
         REG_LIM_Z: lim_z_q = value[LIM_W-1:0];
         REG_OFF_X: off_x_q = value[OFF_W-1:0];
         REG_OFF_Y: off_y_q = value[OFF_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drain the pipe before touching the registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (clipped_expected.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic configure(bit m, int lx, int ly, int lz, int ox, int oy);
      wait_drained();
      write_reg(REG_MODE, m);
      write_reg(REG_LIM_X, lx);
      write_reg(REG_LIM_Y, ly);
      write_reg(REG_LIM_Z, lz);
      write_reg(REG_OFF_X, ox);
      write_reg(REG_OFF_Y, oy);
   endtask

   // Send one request; valid stays high across back-to-back requests
   task automatic send_velocity(int x, int y, int z);
      vel_type d;
      while (!quiet_tx && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      d.x = VEL_W'(x); d.y = VEL_W'(y); d.z = VEL_W'(z);
      req_valid     <= 1'b1;
      req_desired_x <= d.x;
      req_desired_y <= d.y;
      req_desired_z <= d.z;
      clipped_expected.push_back(clip_velocity(d));
      do @(posedge clock); while (req_stall);
   endtask

   function automatic int rand_vel();
      case ($urandom_range(5))
         0: return $urandom_range(3) - 2;                      // near zero
         1: return ($urandom_range(1) ? 32767 : -32768) - $urandom_range(3);
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   task automatic test_box_directed();
      configure(0, 1024, 2048, 512, 300, -700);
      send_velocity(32767, 32767, 32767);
      send_velocity(-32768, -32768, -32768);
      send_velocity(0, 0, 0);
      send_velocity(500, -500, -100);
      configure(0, 0, 32767, 0, 32767, -32768);      // extreme limits / offsets
      send_velocity(32767, -32768, 32767);
      send_velocity(-32768, 32767, -32768);
      configure(0, 100, 100, 100, -32768, 32767);
      send_velocity(-32768, 32767, 5);
      send_velocity(32767, -32768, -5);
      wait_drained();
   endtask

   task automatic test_ellipsoid_directed();
      configure(1, 32767, 32767, 32767, 0, 0);
      send_velocity(0, 0, 32767);                     // on the z axis
      send_velocity(0, 0, -32768);
      send_velocity(0, 0, 0);
      send_velocity(-32768, -32768, -32768);
      send_velocity(32767, 32767, 32767);
      send_velocity(1, 0, 0);
      send_velocity(0, -1, 0);
      configure(1, 1000, 0, 20000, 500, -32768);
      send_velocity(0, 0, 30000);
      send_velocity(3000, 4000, 0);
      send_velocity(-32768, 1, 32767);
      send_velocity(12, -7, -32768);
      wait_drained();
   endtask

   task automatic test_random(int n, bit m);
      configure(m, $urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                int'($signed(16'($urandom))), int'($signed(16'($urandom))));
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            // hold off until everything queued has come back
            req_valid <= 1'b0;
            while (clipped_expected.size() != 0) @(posedge clock);
         end
         if ($urandom_range(9) == 0) send_velocity(0, 0, rand_vel());
         else send_velocity(rand_vel(), rand_vel(), rand_vel());
      end
      wait_drained();
   endtask

   task automatic test_no_idle();
      quiet_tx = 1; quiet_rx = 1;
      test_random(150, 1);
      quiet_tx = 0; quiet_rx = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_desired_x = '0; req_desired_y = '0; req_desired_z = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      mode_q = 1'b0;
      lim_x_q = 15'h7fff; lim_y_q = 15'h7fff; lim_z_q = 15'h7fff;
      off_x_q = '0; off_y_q = '0;
      mismatches = 0; quiet_tx = 0; quiet_rx = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_velocity(32767, -32768, 100);    // reset values, box mode
      wait_drained();
      test_box_directed();
      test_ellipsoid_directed();
      for (int k = 0; k < 8; k++) test_random(215, k[0]);
      test_no_idle();
      if (mismatches == 0)
         $display("velocity_box_ellipsoid_clipper verification clean");
      else
         $display("velocity_box_ellipsoid_clipper verification failed");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
rtl/vbec_pkg.sv
rtl/vbec_front.sv
rtl/vbec_root.sv
rtl/vbec_clamp.sv
rtl/velocity_box_ellipsoid_clipper.sv
sim/velocity_box_ellipsoid_clipper_tb.sv
